### rtl/cube_map_face_and_coord_unit_defines.svh
// ----------------------------------------------------------------------------
// cube map face and coordinate unit: assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef CUBE_MAP_FACE_AND_COORD_UNIT_DEFINES_SVH
`define CUBE_MAP_FACE_AND_COORD_UNIT_DEFINES_SVH

// same-cycle implication, reset masks the check
`define CMF_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masks the check
`define CMF_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/cmf_pkg.sv
// ----------------------------------------------------------------------------
// cmf_pkg
// shared types and constants of the cube map face and coordinate unit
// ----------------------------------------------------------------------------
package cmf_pkg;

  localparam int CMF_COMP_BITS = 16;
  localparam int CMF_FRAC_BITS = 16;
  localparam int FACE_BITS     = 3;

  // face codes
  localparam logic [FACE_BITS-1:0] FACE_POS_Y = 3'd0;
  localparam logic [FACE_BITS-1:0] FACE_NEG_X = 3'd1;
  localparam logic [FACE_BITS-1:0] FACE_POS_Z = 3'd2;
  localparam logic [FACE_BITS-1:0] FACE_POS_X = 3'd3;
  localparam logic [FACE_BITS-1:0] FACE_NEG_Y = 3'd4;
  localparam logic [FACE_BITS-1:0] FACE_NEG_Z = 3'd5;

  // per-beat side info carried alongside the divider lanes
  typedef struct packed {
    logic [FACE_BITS-1:0] face;
    logic                 zero;
    logic                 neg_u;
    logic                 neg_v;
  } side_t;

endpackage

### rtl/cmf_abs.sv
// ----------------------------------------------------------------------------
// cmf_abs
// first stage: component magnitudes and signs
// ----------------------------------------------------------------------------
module cmf_abs
  import cmf_pkg::*;
#(
  parameter int COMP_BITS = CMF_COMP_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic [COMP_BITS-1:0] x_in,
  input  logic [COMP_BITS-1:0] y_in,
  input  logic [COMP_BITS-1:0] z_in,
  output logic                 vld,
  output logic [COMP_BITS-1:0] ax,
  output logic [COMP_BITS-1:0] ay,
  output logic [COMP_BITS-1:0] az,
  output logic                 sx,
  output logic                 sy,
  output logic                 sz
);

  // most negative value negates to its exact unsigned magnitude
  function automatic logic [COMP_BITS-1:0] mag(input logic [COMP_BITS-1:0] v);
    return v[COMP_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= mag(x_in);
      ay <= mag(y_in);
      az <= mag(z_in);
      sx <= x_in[COMP_BITS-1];
      sy <= y_in[COMP_BITS-1];
      sz <= z_in[COMP_BITS-1];
    end
  end

endmodule

### rtl/cmf_select.sv
// ----------------------------------------------------------------------------
// cmf_select
// second stage: major axis pick, face code, minor operands and signs
// ----------------------------------------------------------------------------
module cmf_select
  import cmf_pkg::*;
#(
  parameter int COMP_BITS = CMF_COMP_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic [COMP_BITS-1:0] ax,
  input  logic [COMP_BITS-1:0] ay,
  input  logic [COMP_BITS-1:0] az,
  input  logic                 sx,
  input  logic                 sy,
  input  logic                 sz,
  output logic                 vld,
  output logic [COMP_BITS-1:0] major,
  output logic [COMP_BITS-1:0] minor_u,
  output logic [COMP_BITS-1:0] minor_v,
  output side_t                side
);

  logic                 x_maj;
  logic                 y_maj;
  logic [COMP_BITS-1:0] major_next;
  logic [COMP_BITS-1:0] minor_u_next;
  logic [COMP_BITS-1:0] minor_v_next;
  side_t                side_next;

  assign x_maj = (ax >= ay) && (ax >= az);
  assign y_maj = (ay >= az);

  // neg = (minor < 0) != (major < 0), inverted where the face takes minus
  always_comb begin
    side_next.zero = (ax == '0) && (ay == '0) && (az == '0);
    if (x_maj) begin
      major_next   = ax;
      minor_u_next = az;
      minor_v_next = ay;
      side_next.face  = sx ? FACE_NEG_X : FACE_POS_X;
      side_next.neg_u = ~(sz ^ sx);
      side_next.neg_v = sx ? ~(sy ^ sx) : (sy ^ sx);
    end else if (y_maj) begin
      major_next   = ay;
      minor_u_next = ax;
      minor_v_next = az;
      side_next.face  = sy ? FACE_NEG_Y : FACE_POS_Y;
      side_next.neg_u = sy ? ~(sx ^ sy) : (sx ^ sy);
      side_next.neg_v = ~(sz ^ sy);
    end else begin
      major_next   = az;
      minor_u_next = ax;
      minor_v_next = ay;
      side_next.face  = sz ? FACE_NEG_Z : FACE_POS_Z;
      side_next.neg_u = sz ? ~(sx ^ sz) : (sx ^ sz);
      side_next.neg_v = sy ^ sz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      major   <= major_next;
      minor_u <= minor_u_next;
      minor_v <= minor_v_next;
      side    <= side_next;
    end
  end

endmodule

### rtl/cmf_div_step.sv
// ----------------------------------------------------------------------------
// cmf_div_step
// one restoring division step for both coordinate lanes, registered
// ----------------------------------------------------------------------------
module cmf_div_step
  import cmf_pkg::*;
#(
  parameter int COMP_BITS = CMF_COMP_BITS,
  parameter int FRAC_BITS = CMF_FRAC_BITS,
  parameter bit FIRST     = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic [COMP_BITS-1:0] major_in,
  input  logic [COMP_BITS-1:0] rem_u_in,
  input  logic [COMP_BITS-1:0] rem_v_in,
  input  logic [FRAC_BITS-1:0] quo_u_in,
  input  logic [FRAC_BITS-1:0] quo_v_in,
  input  side_t                side_in,
  output logic                 vld,
  output logic [COMP_BITS-1:0] major,
  output logic [COMP_BITS-1:0] rem_u,
  output logic [COMP_BITS-1:0] rem_v,
  output logic [FRAC_BITS-1:0] quo_u,
  output logic [FRAC_BITS-1:0] quo_v,
  output side_t                side
);

  logic [COMP_BITS:0]   den;
  logic [COMP_BITS:0]   t_u;
  logic [COMP_BITS:0]   t_v;
  logic                 q_u;
  logic                 q_v;
  logic [COMP_BITS:0]   d_u;
  logic [COMP_BITS:0]   d_v;

  // first step takes the top quotient bit without doubling
  assign den = {1'b0, major_in};
  assign t_u = FIRST ? {1'b0, rem_u_in} : {rem_u_in, 1'b0};
  assign t_v = FIRST ? {1'b0, rem_v_in} : {rem_v_in, 1'b0};
  assign q_u = (t_u >= den);
  assign q_v = (t_v >= den);
  assign d_u = q_u ? (t_u - den) : t_u;
  assign d_v = q_v ? (t_v - den) : t_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      major <= major_in;
      rem_u <= d_u[COMP_BITS-1:0];
      rem_v <= d_v[COMP_BITS-1:0];
      quo_u <= {quo_u_in[FRAC_BITS-2:0], q_u};
      quo_v <= {quo_v_in[FRAC_BITS-2:0], q_v};
      side  <= side_in;
    end
  end

endmodule

### rtl/cmf_finish.sv
// ----------------------------------------------------------------------------
// cmf_finish
// output stage: half offset, sign of the half ratio, zero vector override
// ----------------------------------------------------------------------------
module cmf_finish
  import cmf_pkg::*;
#(
  parameter int FRAC_BITS = CMF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic [FRAC_BITS-1:0] quo_u,
  input  logic [FRAC_BITS-1:0] quo_v,
  input  side_t                side,
  output logic                 vld,
  output logic [FACE_BITS-1:0] face_index,
  output logic [FRAC_BITS:0]   coord_u,
  output logic [FRAC_BITS:0]   coord_v,
  output logic                 zero_vector
);

  localparam logic [FRAC_BITS:0] HALF = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);

  logic [FRAC_BITS:0] u_next;
  logic [FRAC_BITS:0] v_next;

  always_comb begin
    if (side.zero) begin
      u_next = HALF;
      v_next = HALF;
    end else begin
      u_next = side.neg_u ? (HALF - {1'b0, quo_u}) : (HALF + {1'b0, quo_u});
      v_next = side.neg_v ? (HALF - {1'b0, quo_v}) : (HALF + {1'b0, quo_v});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      face_index  <= side.face;
      coord_u     <= u_next;
      coord_v     <= v_next;
      zero_vector <= side.zero;
    end
  end

endmodule

### rtl/cube_map_face_and_coord_unit.sv
// ----------------------------------------------------------------------------
// cube_map_face_and_coord_unit
// stages: abs, select, the divider steps and finish; one quotient bit per
//   divider stage
// throughput: one beat per cycle; the whole pipe holds while a result stalls
// reset: synchronous, clears all stage valid bits, no clearing pass
// ----------------------------------------------------------------------------
module cube_map_face_and_coord_unit
  import cmf_pkg::*;
#(
  parameter int COMP_BITS = CMF_COMP_BITS,
  parameter int FRAC_BITS = CMF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  // direction beats
  input  logic                 dir_valid,
  output logic                 dir_stall,
  input  logic [COMP_BITS-1:0] dir_x,
  input  logic [COMP_BITS-1:0] dir_y,
  input  logic [COMP_BITS-1:0] dir_z,
  // result beats
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [FACE_BITS-1:0] face_index,
  output logic [FRAC_BITS:0]   coord_u,
  output logic [FRAC_BITS:0]   coord_v,
  output logic                 zero_vector
);

  // pipe map:
  //   abs    : magnitudes and sign bits
  //   select : major axis (ties to x then y), face code, minor operands
  //   div    : FRAC_BITS restoring steps, both lanes side by side, giving
  //            q = (|minor| << (FRAC_BITS-1)) / |major| truncated
  //   finish : one half plus or minus q, zero vector forced to the middle
  // one enable for every stage: the pipe moves unless the output register
  // holds a beat that the far side is stalling

  logic en;

  assign en        = ~(result_valid & result_stall);
  assign dir_stall = ~en;

  // abs stage
  logic                 a_vld;
  logic [COMP_BITS-1:0] a_ax;
  logic [COMP_BITS-1:0] a_ay;
  logic [COMP_BITS-1:0] a_az;
  logic                 a_sx;
  logic                 a_sy;
  logic                 a_sz;

  cmf_abs #(
    .COMP_BITS (COMP_BITS)
  ) u_abs (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vld_in (dir_valid),
    .x_in   (dir_x),
    .y_in   (dir_y),
    .z_in   (dir_z),
    .vld    (a_vld),
    .ax     (a_ax),
    .ay     (a_ay),
    .az     (a_az),
    .sx     (a_sx),
    .sy     (a_sy),
    .sz     (a_sz)
  );

  // divider chain taps; tap 0 is the select stage output
  logic                 d_vld   [0:FRAC_BITS];
  logic [COMP_BITS-1:0] d_major [0:FRAC_BITS];
  logic [COMP_BITS-1:0] d_rem_u [0:FRAC_BITS];
  logic [COMP_BITS-1:0] d_rem_v [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] d_quo_u [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] d_quo_v [0:FRAC_BITS];
  side_t                d_side  [0:FRAC_BITS];

  cmf_select #(
    .COMP_BITS (COMP_BITS)
  ) u_select (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (a_vld),
    .ax      (a_ax),
    .ay      (a_ay),
    .az      (a_az),
    .sx      (a_sx),
    .sy      (a_sy),
    .sz      (a_sz),
    .vld     (d_vld[0]),
    .major   (d_major[0]),
    .minor_u (d_rem_u[0]),
    .minor_v (d_rem_v[0]),
    .side    (d_side[0])
  );

  // quotients start empty; each step shifts in one bit, msb first
  assign d_quo_u[0] = '0;
  assign d_quo_v[0] = '0;

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    cmf_div_step #(
      .COMP_BITS (COMP_BITS),
      .FRAC_BITS (FRAC_BITS),
      .FIRST     (i == 0)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .vld_in   (d_vld[i]),
      .major_in (d_major[i]),
      .rem_u_in (d_rem_u[i]),
      .rem_v_in (d_rem_v[i]),
      .quo_u_in (d_quo_u[i]),
      .quo_v_in (d_quo_v[i]),
      .side_in  (d_side[i]),
      .vld      (d_vld[i+1]),
      .major    (d_major[i+1]),
      .rem_u    (d_rem_u[i+1]),
      .rem_v    (d_rem_v[i+1]),
      .quo_u    (d_quo_u[i+1]),
      .quo_v    (d_quo_v[i+1]),
      .side     (d_side[i+1])
    );
  end

  // the last divider tap's major and remainders are not needed past here
  cmf_finish #(
    .FRAC_BITS (FRAC_BITS)
  ) u_finish (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .vld_in      (d_vld[FRAC_BITS]),
    .quo_u       (d_quo_u[FRAC_BITS]),
    .quo_v       (d_quo_v[FRAC_BITS]),
    .side        (d_side[FRAC_BITS]),
    .vld         (result_valid),
    .face_index  (face_index),
    .coord_u     (coord_u),
    .coord_v     (coord_v),
    .zero_vector (zero_vector)
  );

endmodule

### rtl/cmf_checker.sv
// ----------------------------------------------------------------------------
// cmf_checker
// port-level checks of the cube map face and coordinate unit
// ----------------------------------------------------------------------------
`include "cube_map_face_and_coord_unit_defines.svh"

module cmf_checker
  import cmf_pkg::*;
#(
  parameter int COMP_BITS = CMF_COMP_BITS,
  parameter int FRAC_BITS = CMF_FRAC_BITS
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 dir_valid,
  input logic                 dir_stall,
  input logic [COMP_BITS-1:0] dir_x,
  input logic [COMP_BITS-1:0] dir_y,
  input logic [COMP_BITS-1:0] dir_z,
  input logic                 result_valid,
  input logic                 result_stall,
  input logic [FACE_BITS-1:0] face_index,
  input logic [FRAC_BITS:0]   coord_u,
  input logic [FRAC_BITS:0]   coord_v,
  input logic                 zero_vector
);

  localparam logic [FRAC_BITS:0] HALF = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);
  localparam logic [FRAC_BITS:0] ONE  = (FRAC_BITS+1)'(1) << FRAC_BITS;

  // zero vector beats carry +x and both coordinates in the middle
  `CMF_ASSERT_NOW(a_zero_result, clk, rst, result_valid && zero_vector,
    face_index == FACE_POS_X && coord_u == HALF && coord_v == HALF,
    "zero vector result malformed")

  // coordinates never leave the unit interval and faces stay in range
  `CMF_ASSERT_NOW(a_range, clk, rst, result_valid,
    coord_u <= ONE && coord_v <= ONE && face_index <= FACE_NEG_Z,
    "result out of range")

  // input side only stalls while a result is held back
  `CMF_ASSERT_NOW(a_stall_cause, clk, rst, dir_stall,
    result_valid && result_stall, "input stalled without output backpressure")

  // a stalled result beat stays put
  `CMF_ASSERT_NEXT(a_hold, clk, rst, result_valid && result_stall,
    result_valid && $stable(face_index) && $stable(coord_u) && $stable(coord_v)
      && $stable(zero_vector),
    "stalled result beat changed")

  // a stalled direction beat stays put
  `CMF_ASSERT_NEXT(a_dir_hold, clk, rst, dir_valid && dir_stall,
    dir_valid && $stable(dir_x) && $stable(dir_y) && $stable(dir_z),
    "stalled direction beat changed")

endmodule

bind cube_map_face_and_coord_unit cmf_checker #(
  .COMP_BITS (COMP_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_cmf_checker (.*);
